>>> rtl/core/assert_macros.svh
// Assertion macros shared by the oscillator RTL modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MWO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwo assertion failed");

// Next-cycle implication, checked out of reset.
`define MWO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mwo assertion failed");

`endif

>>> rtl/core/mwo_pkg.sv
// Package for the multi-waveform oscillator: types, constants, sine table function.
// No dependencies.
`default_nettype none

package mwo_pkg;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef enum logic [1:0] {
        CFG_WAVEFORM_KIND = 2'd0,
        CFG_PEAK_LEVEL    = 2'd1,
        CFG_START_PHASE   = 2'd2,
        CFG_PHASE_STEP    = 2'd3
    } t_cfg_idx;

    localparam int PEAK_W      = 15;
    localparam int SAMPLE_W    = 16;
    localparam int TURN_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = PEAK_W + MAG_W;
    localparam int PROD_SHIFT  = MAG_W - 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [MAG_W-1:0] MAG_ONE = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Work item handed from the front part to the back part.
    typedef struct packed {
        logic              sine;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } t_work;

    // Q15 quarter-wave sine entry, Q30 Taylor series through x^13.
    function automatic logic [15:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (PI_HALF_Q30 * 64'(idx)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/multi_waveform_oscillator_unit.sv
// Top level of the multi-waveform oscillator: config registers, front, queue, back.
// Depends on mwo_pkg, mwo_front, mwo_queue, mwo_back.
//
// Channel   Direction  Handshake                 Payload
// input     in         push / full               i_start_req
// result    out        empty / pop               o_sample
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One transaction in and one out per cycle sustained while the queue is not full and
// results are popped; the front state updates on each accepted tick, so ticks may be pushed back to back.
// A sample passes the queue write, then the registered sine ROM read, the 15x32 peak
// multiply and the sign/output register before it is visible; a held pop stalls it.
// A four-entry queue lets the front keep taking transactions while results wait.
// Reset is synchronous, active low, and clears config, control and valid state, not data registers.
`default_nettype none

module multi_waveform_oscillator_unit #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic                                 i_start_req,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [mwo_pkg::SAMPLE_W-1:0]       o_sample,
    input  wire logic                                 i_cfg_we,
    input  wire logic [1:0]                           i_cfg_idx,
    input  wire logic [mwo_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    mwo_pkg::t_wave                       r_waveform_kind;
    logic [mwo_pkg::PEAK_W-1:0]           r_peak_level;
    logic [mwo_pkg::TURN_W-1:0]           r_start_phase;
    logic signed [mwo_pkg::TURN_W-1:0]    r_phase_step;

    logic              w_push;
    mwo_pkg::t_work    w_front_work;
    logic              w_q_valid;
    logic              w_q_pop;
    mwo_pkg::t_work    w_q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform_kind <= mwo_pkg::WAVE_SINE;
            r_peak_level    <= '0;
            r_start_phase   <= '0;
            r_phase_step    <= '0;
        end else if (i_cfg_we) begin
            unique case (mwo_pkg::t_cfg_idx'(i_cfg_idx))
                mwo_pkg::CFG_WAVEFORM_KIND: r_waveform_kind <= mwo_pkg::t_wave'(i_cfg_data[1:0]);
                mwo_pkg::CFG_PEAK_LEVEL:    r_peak_level    <= i_cfg_data[mwo_pkg::PEAK_W-1:0];
                mwo_pkg::CFG_START_PHASE:   r_start_phase   <= i_cfg_data;
                mwo_pkg::CFG_PHASE_STEP:    r_phase_step    <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    mwo_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_start_req     (i_start_req),
        .i_full          (full),
        .i_waveform_kind (r_waveform_kind),
        .i_start_phase   (r_start_phase),
        .i_phase_step    (r_phase_step),
        .o_push          (w_push),
        .o_work          (w_front_work)
    );

    mwo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_work  (w_q_work)
    );

    mwo_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_work     (w_q_work),
        .i_peak_level (r_peak_level),
        .i_pop        (pop),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .o_sample     (o_sample)
    );

endmodule

`default_nettype wire

>>> rtl/core/mwo_front.sv
// Front part: accepts ticks, advances phase/saw/direction state, classifies the sample.
// Depends on mwo_pkg and assert_macros.svh.
`default_nettype none

module mwo_front #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire logic                              i_start_req,
    input  wire logic                              i_full,
    input  wire mwo_pkg::t_wave                    i_waveform_kind,
    input  wire logic [mwo_pkg::TURN_W-1:0]        i_start_phase,
    input  wire logic signed [mwo_pkg::TURN_W-1:0] i_phase_step,
    output logic                                   o_push,
    output mwo_pkg::t_work                         o_work
);

    localparam int SHL       = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
    localparam int SHR       = (PHASE_BITS < 24) ? 24 - PHASE_BITS : 0;
    localparam int P32_SHIFT = 32 - PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [SINE_TABLE_BITS:0] TBL_N = {1'b1, {SINE_TABLE_BITS{1'b0}}};
    localparam logic signed [PHASE_BITS+1:0] TURN_MAX = {2'b00, {PHASE_BITS{1'b1}}};

    logic [PHASE_BITS-1:0]            r_phase;
    logic [PHASE_BITS-1:0]            n_phase;
    logic [mwo_pkg::TURN_W-1:0]       r_saw;
    logic                             r_ramp;
    logic                             n_ramp;

    logic                             w_accept;
    logic signed [32:0]               w_step_wide;
    logic [32:0]                      w_start_wide;
    logic signed [PHASE_BITS-1:0]     w_step;
    logic [PHASE_BITS-1:0]            w_cur_phase;
    logic [mwo_pkg::TURN_W-1:0]       w_cur_saw;
    logic                             w_cur_ramp;
    logic [31:0]                      w_p32;
    logic [SINE_TABLE_BITS-1:0]       w_idx;
    logic [SINE_TABLE_BITS:0]         w_addr;
    logic [mwo_pkg::TURN_W-1:0]       w_saw_m;
    logic [PHASE_BITS-1:0]            w_tri_m;
    logic signed [PHASE_BITS+1:0]     w_step_ext;
    logic signed [PHASE_BITS+1:0]     w_eff;
    logic signed [PHASE_BITS+1:0]     w_tri_next;
    logic                             w_turn;
    logic                             w_tri_sel;
    logic                             w_flip;

    assign w_accept = i_push && !i_full;
    assign o_push   = w_accept;

    // Phase scaling of the 24-bit register values to PHASE_BITS.
    assign w_step_wide  = ($signed({{9{i_phase_step[23]}}, i_phase_step}) <<< SHL) >>> SHR;
    assign w_start_wide = ({9'd0, i_start_phase} << SHL) >> SHR;
    assign w_step       = w_step_wide[PHASE_BITS-1:0];

    assign w_cur_phase = i_start_req ? w_start_wide[PHASE_BITS-1:0] : r_phase;
    assign w_cur_saw   = i_start_req ? (i_start_phase >> 1) : r_saw;
    assign w_cur_ramp  = i_start_req ? 1'b0 : r_ramp;

    // Sine table address with quarter-wave mirroring.
    assign w_p32  = 32'(w_cur_phase) << P32_SHIFT;
    assign w_idx  = w_p32[29 -: SINE_TABLE_BITS];
    assign w_addr = w_p32[30] ? (TBL_N - {1'b0, w_idx}) : {1'b0, w_idx};

    assign w_saw_m = w_cur_saw[23] ? (24'd0 - w_cur_saw) : w_cur_saw;
    assign w_tri_m = (w_cur_phase >= HALF) ? (w_cur_phase - HALF) : (HALF - w_cur_phase);

    // Triangle stepping with reversal at the turn ends.
    assign w_step_ext = {{2{w_step[PHASE_BITS-1]}}, w_step};
    assign w_eff      = w_cur_ramp ? -w_step_ext : w_step_ext;
    assign w_tri_next = $signed({2'b00, w_cur_phase}) + w_eff;
    assign w_turn     = (w_tri_next > TURN_MAX) || w_tri_next[PHASE_BITS+1]
                        || (w_tri_next == '0);

    assign w_tri_sel = (i_waveform_kind == mwo_pkg::WAVE_TRIANGLE);
    assign w_flip    = (n_ramp != w_cur_ramp);

    always_comb begin
        o_work = '0;
        unique case (i_waveform_kind)
            mwo_pkg::WAVE_SINE: begin
                o_work.sine = 1'b1;
                o_work.neg  = w_p32[31];
                o_work.mag  = mwo_pkg::MAG_W'(w_addr);
            end
            mwo_pkg::WAVE_SAW: begin
                o_work.neg = w_cur_saw[23];
                o_work.mag = {w_saw_m, 8'd0};
            end
            mwo_pkg::WAVE_SQUARE: begin
                o_work.neg = !(w_cur_phase > HALF);
                o_work.mag = mwo_pkg::MAG_ONE;
            end
            mwo_pkg::WAVE_TRIANGLE: begin
                o_work.neg = (w_cur_phase < HALF);
                o_work.mag = mwo_pkg::MAG_W'(w_tri_m) << P32_SHIFT;
            end
            default: begin
                o_work = '0;
            end
        endcase
    end

    always_comb begin
        n_phase = w_cur_phase + $unsigned(w_step);
        n_ramp  = w_cur_ramp;
        if (i_waveform_kind == mwo_pkg::WAVE_TRIANGLE) begin
            if (w_turn) begin
                n_phase = w_cur_phase;
                n_ramp  = !w_cur_ramp;
            end else begin
                n_phase = w_tri_next[PHASE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_saw   <= '0;
            r_ramp  <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_saw   <= w_cur_saw + $unsigned(i_phase_step);
            r_ramp  <= n_ramp;
        end
    end

`include "assert_macros.svh"

    // A direction flip in triangle mode always leaves the phase in place.
    `MWO_ASSERT_NEXT(a_front_tri_hold, w_accept && w_flip, r_phase == $past(w_cur_phase))
    // Direction only changes in triangle mode.
    `MWO_ASSERT_NEXT(a_front_ramp_kind, w_accept && !w_tri_sel, r_ramp == $past(w_cur_ramp))

endmodule

`default_nettype wire

>>> rtl/core/mwo_queue.sv
// Short work queue between the front and back parts.
// Depends on mwo_pkg and assert_macros.svh.
`default_nettype none

module mwo_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mwo_pkg::t_work i_work,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output mwo_pkg::t_work      o_work
);

    localparam int DEPTH = mwo_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwo_pkg::t_work    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "assert_macros.svh"

    `MWO_ASSERT_NEXT(a_queue_fill, w_wr && !w_rd, r_count == $past(r_count) + 1'b1)
    `MWO_ASSERT_NEXT(a_queue_drain, w_rd && !w_wr, r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

>>> rtl/core/mwo_back.sv
// Back part: sine ROM read, peak multiply, sign and output register.
// Depends on mwo_pkg and assert_macros.svh.
`default_nettype none

module mwo_back #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    input  wire mwo_pkg::t_work                    i_q_work,
    input  wire logic [mwo_pkg::PEAK_W-1:0]        i_peak_level,
    input  wire logic                              i_pop,
    output logic                                   o_q_pop,
    output logic                                   o_empty,
    output logic signed [mwo_pkg::SAMPLE_W-1:0]    o_sample
);

    localparam int TBL_N  = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;

    logic [15:0] w_rom [0:TBL_N];

    for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
        assign w_rom[g] = mwo_pkg::sine_entry(g, SINE_TABLE_BITS);
    end

    logic                               r_a_valid;
    logic                               r_a_sine;
    logic                               r_a_neg;
    logic [mwo_pkg::MAG_W-1:0]          r_a_mag;
    logic [15:0]                        r_a_rom;
    logic                               r_b_valid;
    logic                               r_b_neg;
    logic [mwo_pkg::PROD_W-1:0]         r_b_prod;
    logic                               r_c_valid;
    logic [mwo_pkg::SAMPLE_W-1:0]       r_c_sample;

    logic                               w_en_a;
    logic                               w_en_b;
    logic                               w_en_c;
    logic [mwo_pkg::MAG_W-1:0]          w_mag;
    logic [mwo_pkg::SAMPLE_W-1:0]       w_abs;

    assign w_en_c  = !r_c_valid || i_pop;
    assign w_en_b  = !r_b_valid || w_en_c;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_q_pop = w_en_a && i_q_valid;

    assign w_mag = r_a_sine ? {r_a_rom, 16'd0} : r_a_mag;
    assign w_abs = r_b_prod[mwo_pkg::PROD_W-1:mwo_pkg::PROD_SHIFT];

    assign o_empty  = !r_c_valid;
    assign o_sample = $signed(r_c_sample);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_sine <= i_q_work.sine;
            r_a_neg  <= i_q_work.neg;
            r_a_mag  <= i_q_work.mag;
            r_a_rom  <= w_rom[i_q_work.mag[ADDR_W-1:0]];
        end
        if (w_en_b && r_a_valid) begin
            r_b_neg  <= r_a_neg;
            r_b_prod <= i_peak_level * w_mag;
        end
        if (w_en_c && r_b_valid) begin
            r_c_sample <= r_b_neg ? (mwo_pkg::SAMPLE_W'(0) - w_abs) : w_abs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_q_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

`include "assert_macros.svh"

    `MWO_ASSERT_NEXT(a_back_advance, r_b_valid && !r_c_valid, r_c_valid)
    `MWO_ASSERT_SAME(a_back_bound, r_b_valid, w_abs <= {1'b0, i_peak_level})

endmodule

`default_nettype wire
